[rtl/m3i_pkg.sv]
// ----------------------------------------------------------------------------
// m3i_pkg: shared widths and types for the 3x3 matrix inverse
// Element format, derived intermediate widths and the front-to-back item.
// ----------------------------------------------------------------------------
package m3i_pkg;

   localparam int ELEM_WIDTH = 16;
   localparam int FRAC_BITS  = 8;
   localparam int NUM_ELEMS  = 9;

   localparam int PROD_WIDTH = 2 * ELEM_WIDTH;          // element product
   localparam int COF_WIDTH  = 2 * ELEM_WIDTH + 1;      // cofactor, signed
   localparam int CMAG_WIDTH = 2 * ELEM_WIDTH;          // cofactor magnitude
   localparam int DPRD_WIDTH = ELEM_WIDTH + COF_WIDTH;  // det partial product
   localparam int DET_WIDTH  = DPRD_WIDTH + 2;          // sum of three
   localparam int NUM_WIDTH  = CMAG_WIDTH + 2 * FRAC_BITS;
   localparam int QUO_BITS   = ELEM_WIDTH + 1;          // quotient bits kept
   localparam int REM_WIDTH  = (NUM_WIDTH > DET_WIDTH + QUO_BITS) ?
                               NUM_WIDTH : DET_WIDTH + QUO_BITS;

   localparam logic [ELEM_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
   localparam logic [ELEM_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic signed [COF_WIDTH-1:0]  cof_type;
   typedef logic signed [DET_WIDTH-1:0]  det_type;

   typedef struct packed {
      cof_type [NUM_ELEMS-1:0] cof;
      det_type                 det;
      logic                    singular;
   } work_type;

endpackage

[rtl/m3i_if.sv]
// ----------------------------------------------------------------------------
// m3i_if: request and response channels of the 3x3 matrix inverse
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface m3i_req_if;
   logic valid;
   logic ready;
   m3i_pkg::elem_type m00, m01, m02, m10, m11, m12, m20, m21, m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   output ready);
endinterface

interface m3i_rsp_if;
   logic valid;
   logic ready;
   m3i_pkg::elem_type r00, r01, r02, r10, r11, r12, r20, r21, r22;
   logic singular;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, output ready);
endinterface

[rtl/matrix3x3_inverse.sv]
// ----------------------------------------------------------------------------
// matrix3x3_inverse: inverse of a 3x3 signed Q8.8 matrix
// Adjugate over determinant, exact quotients truncated toward zero and
// saturated; a zero determinant returns zeros with the singular flag.
// ----------------------------------------------------------------------------
//  channel   dir   payload                      handshake
//  req_ch    in    m00..m22 (Q8.8, row-major)   valid/ready
//  rsp_ch    out   r00..r22 (Q8.8), singular    valid/ready
//
//  Throughput is one item per cycle while rsp_ch does not stall; the nine
//  dividers are fully pipelined, one restoring step per quotient bit
//  (QUO_BITS = ELEM_WIDTH+1 steps). Each Q8.8 item passes through the front
//  stages, the queue, then the setup stage, steps and output register of the back.
//  Reset clears the valid bits, queue pointers and queue count only; no clearing pass.
//  A stalled rsp_ch freezes the back; the two-entry queue absorbs the front
//  until it fills, then req_ch.ready drops.
// ----------------------------------------------------------------------------
module matrix3x3_inverse (
   input  logic       clock,
   input  logic       reset,
   m3i_req_if.sink    req_ch,
   m3i_rsp_if.source  rsp_ch
);

   // front to queue
   m3i_pkg::work_type front_data;
   logic              front_valid, front_ready;

   // queue to back
   m3i_pkg::work_type back_data;
   logic              back_valid, back_ready;

   // determinant, cofactors and singular flag
   m3i_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .out_data  (front_data),
      .out_valid (front_valid),
      .out_ready (front_ready)
   );

   m3i_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_data   (front_data),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_data  (back_data),
      .out_valid (back_valid),
      .out_ready (back_ready)
   );

   // division and saturation
   m3i_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_data  (back_data),
      .in_valid (back_valid),
      .in_ready (back_ready),
      .rsp      (rsp_ch)
   );

endmodule

[rtl/m3i_front.sv]
// ----------------------------------------------------------------------------
// m3i_front: cofactors and determinant
// Four stalling stages: products, cofactors, det partials, det sum and flag.
// ----------------------------------------------------------------------------
module m3i_front (
   input  logic               clock,
   input  logic               reset,
   m3i_req_if.sink            req,
   output m3i_pkg::work_type  out_data,
   output logic               out_valid,
   input  logic               out_ready
);

   localparam int PW = m3i_pkg::PROD_WIDTH;
   localparam int CW = m3i_pkg::COF_WIDTH;
   localparam int DP = m3i_pkg::DPRD_WIDTH;
   localparam int DW = m3i_pkg::DET_WIDTH;
   localparam int NE = m3i_pkg::NUM_ELEMS;

   logic advance;
   logic [3:0] vld_ff, vld_in;

   m3i_pkg::elem_type a [NE];
   logic signed [PW-1:0] prod_ff [2*NE];
   m3i_pkg::elem_type    row1_ff [3], row2_ff [3];
   m3i_pkg::cof_type     cof2_ff [NE], cof3_ff [NE];
   logic signed [DP-1:0] dp_ff [3];
   m3i_pkg::work_type    work_ff;

   assign advance   = !vld_ff[3] || out_ready;
   assign req.ready = advance;
   assign out_valid = vld_ff[3];
   assign out_data  = work_ff;

   assign a[0] = req.m00;  assign a[1] = req.m01;  assign a[2] = req.m02;
   assign a[3] = req.m10;  assign a[4] = req.m11;  assign a[5] = req.m12;
   assign a[6] = req.m20;  assign a[7] = req.m21;  assign a[8] = req.m22;

   assign vld_in = advance ? {vld_ff[2:0], req.valid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // cofactor k = prod[2k] - prod[2k+1]
         prod_ff[0]  <= PW'(a[4]) * PW'(a[8]);  prod_ff[1]  <= PW'(a[7]) * PW'(a[5]);
         prod_ff[2]  <= PW'(a[2]) * PW'(a[7]);  prod_ff[3]  <= PW'(a[1]) * PW'(a[8]);
         prod_ff[4]  <= PW'(a[1]) * PW'(a[5]);  prod_ff[5]  <= PW'(a[2]) * PW'(a[4]);
         prod_ff[6]  <= PW'(a[5]) * PW'(a[6]);  prod_ff[7]  <= PW'(a[3]) * PW'(a[8]);
         prod_ff[8]  <= PW'(a[0]) * PW'(a[8]);  prod_ff[9]  <= PW'(a[2]) * PW'(a[6]);
         prod_ff[10] <= PW'(a[3]) * PW'(a[2]);  prod_ff[11] <= PW'(a[0]) * PW'(a[5]);
         prod_ff[12] <= PW'(a[3]) * PW'(a[7]);  prod_ff[13] <= PW'(a[6]) * PW'(a[4]);
         prod_ff[14] <= PW'(a[6]) * PW'(a[1]);  prod_ff[15] <= PW'(a[0]) * PW'(a[7]);
         prod_ff[16] <= PW'(a[0]) * PW'(a[4]);  prod_ff[17] <= PW'(a[3]) * PW'(a[1]);
         for (int i = 0; i < 3; i++) begin
            row1_ff[i] <= a[i];
            row2_ff[i] <= row1_ff[i];
         end
         for (int k = 0; k < NE; k++) begin
            cof2_ff[k] <= CW'(prod_ff[2*k]) - CW'(prod_ff[2*k+1]);
            cof3_ff[k] <= cof2_ff[k];
         end
         // expansion along the first row
         dp_ff[0] <= DP'(row2_ff[0]) * DP'(cof2_ff[0]);
         dp_ff[1] <= DP'(row2_ff[1]) * DP'(cof2_ff[3]);
         dp_ff[2] <= DP'(row2_ff[2]) * DP'(cof2_ff[6]);
         for (int k = 0; k < NE; k++) begin
            work_ff.cof[k] <= cof3_ff[k];
         end
         work_ff.det      <= DW'(dp_ff[0]) + DW'(dp_ff[1]) + DW'(dp_ff[2]);
         work_ff.singular <= (DW'(dp_ff[0]) + DW'(dp_ff[1]) + DW'(dp_ff[2])) == '0;
      end
   end

endmodule

[rtl/m3i_queue.sv]
// ----------------------------------------------------------------------------
// m3i_queue: two-entry queue between front and back
// Lets either side stall without holding up the other.
// ----------------------------------------------------------------------------
module m3i_queue (
   input  logic               clock,
   input  logic               reset,
   input  m3i_pkg::work_type  in_data,
   input  logic               in_valid,
   output logic               in_ready,
   output m3i_pkg::work_type  out_data,
   output logic               out_valid,
   input  logic               out_ready
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   m3i_pkg::work_type ent_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]    count_ff, count_in;
   logic push, pop;

   assign in_ready  = count_ff != (PTR_W+1)'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = ent_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

[rtl/m3i_back.sv]
// ----------------------------------------------------------------------------
// m3i_back: nine pipelined dividers and saturation
// Setup stage, one restoring step per quotient bit, then the output register.
// ----------------------------------------------------------------------------
module m3i_back (
   input  logic               clock,
   input  logic               reset,
   input  m3i_pkg::work_type  in_data,
   input  logic               in_valid,
   output logic               in_ready,
   m3i_rsp_if.source          rsp
);

   localparam int NE = m3i_pkg::NUM_ELEMS;
   localparam int QB = m3i_pkg::QUO_BITS;
   localparam int XW = m3i_pkg::REM_WIDTH;
   localparam int DW = m3i_pkg::DET_WIDTH;
   localparam int CW = m3i_pkg::COF_WIDTH;
   localparam int MW = m3i_pkg::CMAG_WIDTH;
   localparam int EW = m3i_pkg::ELEM_WIDTH;
   localparam int FB = m3i_pkg::FRAC_BITS;

   logic advance;
   logic [QB:0]   vld_ff;
   logic          out_vld_ff;

   logic [XW-1:0] rem_ff  [QB+1][NE];
   logic [QB-1:0] quo_ff  [QB+1][NE];
   logic          neg_ff  [QB+1][NE];
   logic          ovf_ff  [QB+1][NE];
   logic [DW-1:0] dmag_ff [QB+1];
   logic          sing_ff [QB+1];

   m3i_pkg::elem_type res_ff [NE];
   logic              res_sing_ff;

   logic [DW-1:0] dmag;
   logic          dneg;
   logic [CW-1:0] cabs [NE];
   logic [XW-1:0] num  [NE];

   assign advance  = !out_vld_ff || rsp.ready;
   assign in_ready = advance;

   always_comb begin
      dneg = in_data.det[DW-1];
      dmag = dneg ? DW'(-in_data.det) : DW'(in_data.det);
      for (int k = 0; k < NE; k++) begin
         cabs[k] = in_data.cof[k][CW-1] ? CW'(-$signed(in_data.cof[k]))
                                        : CW'(in_data.cof[k]);
         num[k]  = XW'(cabs[k][MW-1:0]) << (2 * FB);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff     <= {vld_ff[QB-1:0], in_valid};
         out_vld_ff <= vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // setup: magnitudes, sign, and overflow when quotient >= 2^QB
         dmag_ff[0] <= dmag;
         sing_ff[0] <= in_data.singular;
         for (int k = 0; k < NE; k++) begin
            rem_ff[0][k] <= num[k];
            quo_ff[0][k] <= '0;
            neg_ff[0][k] <= in_data.cof[k][CW-1] != dneg;
            ovf_ff[0][k] <= num[k] >= (XW'(dmag) << QB);
         end
         // one quotient bit per stage, MSB first
         for (int s = 1; s <= QB; s++) begin
            dmag_ff[s] <= dmag_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
            for (int k = 0; k < NE; k++) begin
               neg_ff[s][k] <= neg_ff[s-1][k];
               ovf_ff[s][k] <= ovf_ff[s-1][k];
               if (rem_ff[s-1][k] >= (XW'(dmag_ff[s-1]) << (QB - s))) begin
                  rem_ff[s][k] <= rem_ff[s-1][k] - (XW'(dmag_ff[s-1]) << (QB - s));
                  quo_ff[s][k] <= quo_ff[s-1][k] | (QB'(1) << (QB - s));
               end else begin
                  rem_ff[s][k] <= rem_ff[s-1][k];
                  quo_ff[s][k] <= quo_ff[s-1][k];
               end
            end
         end
         // saturate to element range; zeros when singular
         res_sing_ff <= sing_ff[QB];
         for (int k = 0; k < NE; k++) begin
            if (sing_ff[QB]) begin
               res_ff[k] <= '0;
            end else if (!neg_ff[QB][k]) begin
               if (ovf_ff[QB][k] || quo_ff[QB][k] > QB'(m3i_pkg::ELEM_MAX)) begin
                  res_ff[k] <= m3i_pkg::ELEM_MAX;
               end else begin
                  res_ff[k] <= quo_ff[QB][k][EW-1:0];
               end
            end else begin
               if (ovf_ff[QB][k] || quo_ff[QB][k] > QB'(m3i_pkg::ELEM_MIN)) begin
                  res_ff[k] <= m3i_pkg::ELEM_MIN;
               end else begin
                  res_ff[k] <= EW'(-quo_ff[QB][k]);
               end
            end
         end
      end
   end

   assign rsp.valid    = out_vld_ff;
   assign rsp.singular = res_sing_ff;
   assign rsp.r00 = res_ff[0];  assign rsp.r01 = res_ff[1];  assign rsp.r02 = res_ff[2];
   assign rsp.r10 = res_ff[3];  assign rsp.r11 = res_ff[4];  assign rsp.r12 = res_ff[5];
   assign rsp.r20 = res_ff[6];  assign rsp.r21 = res_ff[7];  assign rsp.r22 = res_ff[8];

endmodule
